>>> hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/mqmj_pkg.sv
package mqmj_pkg;

   localparam int MAX_QUEUES_DEF  = 4;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_WIDTH_DEF    = 16;

   localparam int PORT_W     = 2;
   localparam int MS_W       = 5;
   localparam int QC_W       = 3;
   localparam int NQ_W       = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MATCH_SIZE  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_QUEUE_COUNT = 4'd1;

   localparam logic [MS_W-1:0] MS_RESET = 5'd1;
   localparam logic [QC_W-1:0] QC_RESET = 3'd2;

   // effective configuration seen by the controller
   typedef struct packed {
      logic [MS_W-1:0] need;
      logic [NQ_W-1:0] nq;
   } cfg_type;

   // tags of the result waiting behind the memory read register
   typedef struct packed {
      logic              valid;
      logic [PORT_W-1:0] port;
      logic              dropped;
      logic              last;
      logic              from_mem;
   } stage_type;

endpackage

>>> hw/rtl/mqmj_store.sv
module mqmj_store import mqmj_pkg::*; #(
   parameter int MAX_QUEUES  = MAX_QUEUES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF,
   localparam int DEPTH      = MAX_QUEUES * QUEUE_DEPTH,
   localparam int AW         = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AW-1:0]       waddr,
   input  logic [ID_WIDTH-1:0] wdata,
   input  logic                re,
   input  logic [AW-1:0]       raddr,
   output logic [ID_WIDTH-1:0] rdata
);

   logic [ID_WIDTH-1:0] mem [DEPTH];
   logic [ID_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      // read data holds until the next read
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/mqmj_ctrl.sv
module mqmj_ctrl import mqmj_pkg::*; #(
   parameter int MAX_QUEUES  = MAX_QUEUES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF,
   localparam int QW         = $clog2(MAX_QUEUES),
   localparam int PW         = $clog2(QUEUE_DEPTH),
   localparam int OW         = $clog2(QUEUE_DEPTH + 1),
   localparam int AW         = $clog2(MAX_QUEUES * QUEUE_DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [PORT_W-1:0]   req_port,
   input  logic [ID_WIDTH-1:0] req_entity_id,
   input  logic                stage_pop,
   output stage_type           stage,
   output logic [ID_WIDTH-1:0] drop_id,
   output logic                mem_we,
   output logic [AW-1:0]       mem_waddr,
   output logic [ID_WIDTH-1:0] mem_wdata,
   output logic                mem_re,
   output logic [AW-1:0]       mem_raddr
);

   typedef enum logic {
      ST_IDLE,
      ST_RELEASE
   } state_type;

   state_type           state_ff, state_in;
   logic [PW-1:0]       head_ff [MAX_QUEUES];
   logic [PW-1:0]       head_in [MAX_QUEUES];
   logic [PW-1:0]       tail_ff [MAX_QUEUES];
   logic [PW-1:0]       tail_in [MAX_QUEUES];
   logic [OW-1:0]       occ_ff  [MAX_QUEUES];
   logic [OW-1:0]       occ_in  [MAX_QUEUES];
   stage_type           stage_ff, stage_in;
   logic [ID_WIDTH-1:0] drop_id_ff, drop_id_in;
   logic [QW-1:0]       rel_q_ff, rel_q_in;
   logic [MS_W-1:0]     rel_i_ff, rel_i_in;

   logic [QW-1:0]       pq;
   logic                port_active;
   logic                port_full;
   logic                match;
   logic                slot_free;
   logic                rel_last_i;
   logic                rel_last;

   function automatic logic [AW-1:0] addr_of(input logic [QW-1:0] q,
                                            input logic [PW-1:0] p);
      return AW'(32'(q) * QUEUE_DEPTH + 32'(p));
   endfunction

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign pq          = QW'(req_port);
   assign port_active = 32'(req_port) < 32'(cfg.nq);
   assign port_full   = port_active && (32'(occ_ff[pq]) >= QUEUE_DEPTH);
   assign slot_free   = !stage_ff.valid || stage_pop;
   assign rel_last_i  = rel_i_ff == cfg.need - MS_W'(1);
   assign rel_last    = rel_last_i && (32'(rel_q_ff) + 1 == 32'(cfg.nq));

   // match check against the occupancy after this arrival is stored
   always_comb begin
      logic [OW:0] occ_after;
      match = 1'b1;
      for (int q = 0; q < MAX_QUEUES; q++) begin
         occ_after = {1'b0, occ_ff[q]} + ((QW'(q) == pq) ? (OW+1)'(1) : '0);
         if ((q < int'(cfg.nq)) && (32'(occ_after) < 32'(cfg.need))) begin
            match = 1'b0;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      occ_in     = occ_ff;
      stage_in   = stage_ff;
      drop_id_in = drop_id_ff;
      rel_q_in   = rel_q_ff;
      rel_i_in   = rel_i_ff;
      req_ready  = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_waddr  = addr_of(pq, tail_ff[pq]);
      mem_wdata  = req_entity_id;
      mem_raddr  = addr_of(rel_q_ff, head_ff[rel_q_ff]);
      if (stage_pop) begin
         stage_in.valid = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            req_ready = slot_free;
            if (req_valid && slot_free) begin
               if (!port_active || port_full) begin
                  stage_in   = '{valid: 1'b1, port: req_port, dropped: 1'b1,
                                 last: 1'b1, from_mem: 1'b0};
                  drop_id_in = req_entity_id;
               end else begin
                  mem_we      = 1'b1;
                  tail_in[pq] = wrap_inc(tail_ff[pq]);
                  occ_in[pq]  = occ_ff[pq] + OW'(1);
                  if (match) begin
                     state_in = ST_RELEASE;
                     rel_q_in = '0;
                     rel_i_in = '0;
                  end
               end
            end
         end
         ST_RELEASE: begin
            if (slot_free) begin
               mem_re            = 1'b1;
               head_in[rel_q_ff] = wrap_inc(head_ff[rel_q_ff]);
               occ_in[rel_q_ff]  = occ_ff[rel_q_ff] - OW'(1);
               stage_in = '{valid: 1'b1, port: PORT_W'(rel_q_ff), dropped: 1'b0,
                            last: rel_last, from_mem: 1'b1};
               if (rel_last) begin
                  state_in = ST_IDLE;
               end else if (rel_last_i) begin
                  rel_i_in = '0;
                  rel_q_in = rel_q_ff + QW'(1);
               end else begin
                  rel_i_in = rel_i_ff + MS_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      // payload tags and drop id need no reset
      stage_ff.port     <= stage_in.port;
      stage_ff.dropped  <= stage_in.dropped;
      stage_ff.last     <= stage_in.last;
      stage_ff.from_mem <= stage_in.from_mem;
      drop_id_ff        <= drop_id_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         stage_ff.valid <= 1'b0;
         rel_q_ff       <= '0;
         rel_i_ff       <= '0;
         for (int q = 0; q < MAX_QUEUES; q++) begin
            head_ff[q] <= '0;
            tail_ff[q] <= '0;
            occ_ff[q]  <= '0;
         end
      end else begin
         state_ff       <= state_in;
         stage_ff.valid <= stage_in.valid;
         rel_q_ff       <= rel_q_in;
         rel_i_ff       <= rel_i_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         occ_ff         <= occ_in;
      end
   end

   assign stage   = stage_ff;
   assign drop_id = drop_id_ff;

endmodule

>>> hw/rtl/multi_queue_match_join.sv
// channel   direction  transaction                         handshake
// req_      in         one arrival: port, entity_id        req_valid / req_ready
// rsp_      out        released or dropped entity          rsp_valid / rsp_ready
// csr_      in         register write: index, data         csr_valid / csr_ready
//
// an arrival is taken when req_ready is high, whether it is stored or dropped
// a match drains queue_count * match_size entries at one per cycle while rsp_ready does not
// hold the output, paced by the single read port of the entry memory
// the next arrival is taken once the last read of a match has been issued
// synchronous active-high reset clears pointers, counts and valid flags and loads the config defaults;
// entry memory contents are not cleared, the counts guard every read
// rsp_ready low holds the output register, the read register behind it,
// and then the controller
module multi_queue_match_join import mqmj_pkg::*; #(
   parameter int MAX_QUEUES  = MAX_QUEUES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // arrivals
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PORT_W-1:0]     req_port,
   input  logic [ID_WIDTH-1:0]   req_entity_id,
   // results
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ID_WIDTH-1:0]   rsp_released_id,
   output logic [PORT_W-1:0]     rsp_released_port,
   output logic                  rsp_dropped,
   output logic                  rsp_last,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = $clog2(MAX_QUEUES * QUEUE_DEPTH);

   logic [MS_W-1:0]     match_size_ff, match_size_in;
   logic [QC_W-1:0]     queue_count_ff, queue_count_in;
   cfg_type             cfg;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_WIDTH-1:0] rsp_id_ff, rsp_id_in;
   logic [PORT_W-1:0]   rsp_port_ff, rsp_port_in;
   logic                rsp_dropped_ff, rsp_dropped_in;
   logic                rsp_last_ff, rsp_last_in;

   stage_type           stage;
   logic                stage_pop;
   logic [ID_WIDTH-1:0] drop_id;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [ID_WIDTH-1:0] mem_wdata;
   logic                mem_re;
   logic [AW-1:0]       mem_raddr;
   logic [ID_WIDTH-1:0] mem_rdata;

   // the user must do register writes only while the block is quiet; the block itself does not enforce it
   assign csr_ready = 1'b1;

   always_comb begin
      match_size_in  = match_size_ff;
      queue_count_in = queue_count_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MATCH_SIZE:  match_size_in  = csr_data[MS_W-1:0];
            REG_QUEUE_COUNT: queue_count_in = csr_data[QC_W-1:0];
            default: ;
         endcase
      end
   end

   // zero match size acts as one; queue count is clamped to 1 .. MAX_QUEUES
   always_comb begin
      cfg.need = (match_size_ff == '0) ? MS_W'(1) : match_size_ff;
      if (queue_count_ff == '0) begin
         cfg.nq = NQ_W'(1);
      end else if (int'(queue_count_ff) > MAX_QUEUES) begin
         cfg.nq = NQ_W'(MAX_QUEUES);
      end else begin
         cfg.nq = NQ_W'(queue_count_ff);
      end
   end

   // the read register moves into the output register when that is free
   assign stage_pop = stage.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_id_in      = rsp_id_ff;
      rsp_port_in    = rsp_port_ff;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_last_in    = rsp_last_ff;
      if (stage_pop) begin
         rsp_valid_in   = 1'b1;
         rsp_id_in      = stage.from_mem ? mem_rdata : drop_id;
         rsp_port_in    = stage.port;
         rsp_dropped_in = stage.dropped;
         rsp_last_in    = stage.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_size_ff  <= MS_RESET;
         queue_count_ff <= QC_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         match_size_ff  <= match_size_in;
         queue_count_ff <= queue_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_id_ff      <= rsp_id_in;
      rsp_port_ff    <= rsp_port_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_released_id   = rsp_id_ff;
   assign rsp_released_port = rsp_port_ff;
   assign rsp_dropped       = rsp_dropped_ff;
   assign rsp_last          = rsp_last_ff;

   // queue pointers, counts and release sequencing; writes and reads of the
   // same entry never overlap since releases only start after the write edge
   mqmj_ctrl #(
      .MAX_QUEUES  (MAX_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_port      (req_port),
      .req_entity_id (req_entity_id),
      .stage_pop     (stage_pop),
      .stage         (stage),
      .drop_id       (drop_id),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .mem_re        (mem_re),
      .mem_raddr     (mem_raddr)
   );

   // entry memory, one region of QUEUE_DEPTH ids per queue
   mqmj_store #(
      .MAX_QUEUES  (MAX_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

>>> hw/rtl/mqmj_checker.sv
`include "assert_macros.svh"

module mqmj_protocol_checker import mqmj_pkg::*; #(
   parameter int ID_WIDTH = ID_WIDTH_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [ID_WIDTH-1:0] rsp_released_id,
   input logic [PORT_W-1:0]   rsp_released_port,
   input logic                rsp_dropped,
   input logic                rsp_last
);

   // a stalled result keeps its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_released_id) && $stable(rsp_released_port) && $stable(rsp_dropped) && $stable(rsp_last))

   // a dropped arrival is always the only and final result of its transaction
   `ASSERT_IMPLIES(a_drop_last, clock, reset, rsp_valid && rsp_dropped, rsp_last)

   // no result comes out of reset
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind multi_queue_match_join mqmj_protocol_checker #(.ID_WIDTH(ID_WIDTH)) u_mqmj_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_released_id   (rsp_released_id),
   .rsp_released_port (rsp_released_port),
   .rsp_dropped       (rsp_dropped),
   .rsp_last          (rsp_last)
);
